// ===== rtl/core/stereo_linear_resampler_macros.svh =====
// assertion macros for the stereo linear resampler
`ifndef STEREO_LINEAR_RESAMPLER_MACROS_SVH
`define STEREO_LINEAR_RESAMPLER_MACROS_SVH

// condition must hold at every clock edge outside reset
`define SRS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("srs assertion failed");

// antecedent implies consequent in the same cycle
`define SRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srs assertion failed");

`endif

// ===== rtl/core/srs_pkg.sv =====
// shared types and constants of the stereo linear resampler
package srs_pkg;

    // most results one input item can cause
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // configuration register indexes (byte address / 4)
    localparam int          REG_IDX_W      = 1;
    localparam logic [0:0]  REG_RATE_RATIO = 1'b0;
    localparam logic [0:0]  REG_MONO       = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;        // latch current frame, clear result count
        logic store_first;    // first frame: store as previous only
        logic mul_step;       // register products, advance phase
        logic load_interp;    // load output register with interpolated frame
        logic load_bypass;    // load output register with current frame
        logic finish;         // settle phase, current becomes previous
        logic finish_bypass;  // current becomes previous, phase untouched
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic have_prev;
        logic is_unity;
        logic loop_go;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/srs_datapath.sv =====
// datapath: frame registers, phase accumulator, multipliers, output register
module srs_datapath #(
    parameter int SAMPLE_BITS     = 16,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  srs_pkg::cmd_t                     cmd,
    output srs_pkg::status_t                  st,
    input  logic [SAMPLE_BITS-1:0]            left_in,
    input  logic [SAMPLE_BITS-1:0]            right_in,
    input  logic [PHASE_FRAC_BITS+3:0]        rate_ratio,
    input  logic                              mono_source,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [SAMPLE_BITS-1:0]            left_out,
    output logic [SAMPLE_BITS-1:0]            right_out,
    output logic                              m_tlast
);

    localparam int PW  = PHASE_FRAC_BITS + 4;
    localparam int P_W = SAMPLE_BITS + PHASE_FRAC_BITS + 2;
    localparam int S_W = P_W + 1;
    localparam int CW  = srs_pkg::CNT_W;

    localparam logic [PW-1:0] PHASE_ONE = PW'(1) << PHASE_FRAC_BITS;
    localparam logic [PW-1:0] RATIO_MIN = PHASE_ONE >> 3;
    localparam logic [PW-1:0] RATIO_MAX = PHASE_ONE << 3;
    localparam logic signed [S_W-1:0] ROUND_HALF = S_W'(1) << (PHASE_FRAC_BITS - 1);

    logic [SAMPLE_BITS-1:0]        cur_l_reg, cur_r_reg;
    logic [SAMPLE_BITS-1:0]        prev_l_reg, prev_r_reg;
    logic [PW-1:0]                 phase_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          have_prev_reg;
    logic signed [P_W-1:0]         prod_l_reg, prod_r_reg;
    logic                          last_reg;
    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_l_reg, out_r_reg;
    logic                          out_last_reg;

    logic [SAMPLE_BITS-1:0]        in_r_mapped;
    logic [PW-1:0]                 ratio_clamp;
    logic [PW-1:0]                 phase_sum;
    logic [PW-1:0]                 phase_next;
    logic signed [PHASE_FRAC_BITS:0] ph_s;
    logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
    logic signed [P_W-1:0]         prod_l, prod_r;
    logic signed [S_W-1:0]         sum_l, sum_r;
    logic signed [S_W-1:0]         sh_l, sh_r;
    logic [SAMPLE_BITS-1:0]        res_l, res_r;
    logic                          last_next;

    assign in_r_mapped = mono_source ? left_in : right_in;

    always_comb
    begin
        if (rate_ratio < RATIO_MIN)
        begin
            ratio_clamp = RATIO_MIN;
        end
        else if (rate_ratio > RATIO_MAX)
        begin
            ratio_clamp = RATIO_MAX;
        end
        else
        begin
            ratio_clamp = rate_ratio;
        end
    end

    assign phase_sum  = phase_reg + ratio_clamp;
    assign phase_next = (phase_reg >= PHASE_ONE) ? (phase_reg - PHASE_ONE) : '0;
    assign last_next  = (phase_sum >= PHASE_ONE) ||
                        (cnt_reg == CW'(srs_pkg::MAX_RESULTS - 1));

    // (cur - prev) * phase, phase fraction taken as non-negative
    assign ph_s   = $signed({1'b0, phase_reg[PHASE_FRAC_BITS-1:0]});
    assign diff_l = $signed({cur_l_reg[SAMPLE_BITS-1], cur_l_reg}) -
                    $signed({prev_l_reg[SAMPLE_BITS-1], prev_l_reg});
    assign diff_r = $signed({cur_r_reg[SAMPLE_BITS-1], cur_r_reg}) -
                    $signed({prev_r_reg[SAMPLE_BITS-1], prev_r_reg});
    assign prod_l = P_W'(diff_l) * P_W'(ph_s);
    assign prod_r = P_W'(diff_r) * P_W'(ph_s);

    // round half up: floor((prod + half) / one), then add previous sample
    assign sum_l = $signed({prod_l_reg[P_W-1], prod_l_reg}) + ROUND_HALF;
    assign sum_r = $signed({prod_r_reg[P_W-1], prod_r_reg}) + ROUND_HALF;
    assign sh_l  = sum_l >>> PHASE_FRAC_BITS;
    assign sh_r  = sum_r >>> PHASE_FRAC_BITS;
    assign res_l = prev_l_reg + sh_l[SAMPLE_BITS-1:0];
    assign res_r = prev_r_reg + sh_r[SAMPLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            phase_reg     <= '0;
            have_prev_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                cnt_reg <= '0;
            end
            if (cmd.store_first)
            begin
                prev_l_reg    <= left_in;
                prev_r_reg    <= in_r_mapped;
                have_prev_reg <= 1'b1;
            end
            if (cmd.mul_step)
            begin
                phase_reg <= phase_sum;
                cnt_reg   <= cnt_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                phase_reg     <= phase_next;
                prev_l_reg    <= cur_l_reg;
                prev_r_reg    <= cur_r_reg;
                have_prev_reg <= 1'b1;
            end
            if (cmd.finish_bypass)
            begin
                prev_l_reg    <= cur_l_reg;
                prev_r_reg    <= cur_r_reg;
                have_prev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_l_reg <= left_in;
            cur_r_reg <= in_r_mapped;
        end
        if (cmd.mul_step)
        begin
            prod_l_reg <= prod_l;
            prod_r_reg <= prod_r;
            last_reg   <= last_next;
        end
        if (cmd.load_interp)
        begin
            out_l_reg    <= res_l;
            out_r_reg    <= res_r;
            out_last_reg <= last_reg;
        end
        else if (cmd.load_bypass)
        begin
            out_l_reg    <= cur_l_reg;
            out_r_reg    <= cur_r_reg;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_interp || cmd.load_bypass)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign st.have_prev = have_prev_reg;
    assign st.is_unity  = (rate_ratio == PHASE_ONE);
    assign st.loop_go   = (phase_reg < PHASE_ONE) &&
                          (cnt_reg < CW'(srs_pkg::MAX_RESULTS));
    assign st.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;
    assign m_tlast   = out_last_reg;

endmodule

// ===== rtl/core/srs_controller.sv =====
// controller state machine: sequences accept, multiply, emit, finish and unity bypass
module srs_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  srs_pkg::status_t  st,
    output srs_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MUL    = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;
    localparam logic [1:0] S_BYPASS = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    if (st.is_unity)
                    begin
                        state_next = S_BYPASS;
                    end
                    else if (st.have_prev)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        cmd.store_first = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (st.loop_go)
                begin
                    cmd.mul_step = 1'b1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.load_interp = 1'b1;
                    state_next      = S_MUL;
                end
            end
            S_BYPASS:
            begin
                if (st.out_free)
                begin
                    cmd.load_bypass   = 1'b1;
                    cmd.finish_bypass = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/stereo_linear_resampler.sv =====
// stereo linear resampler top level: config registers, controller and datapath
// an item with n results: accept, a multiply and an emit step per result, then
//   phase settle; at unity ratio accept then bypass; otherwise the first frame after
//   reset is only stored; no new item is taken until the current one is finished
// a held-back result stalls emit and bypass, which load the output register
// rst_n, async active low: ratio 1.0, mono off; phase, prev frame, m_tvalid cleared
`include "stereo_linear_resampler_macros.svh"

module stereo_linear_resampler #(
    parameter int  SAMPLE_BITS     = 16,
    parameter int  PHASE_FRAC_BITS = 16,
    localparam int TDATA_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // left_in, right_in
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // left_out, right_out, zero pad
    output logic                m_tlast    // last_of_run
);

    localparam int PW = PHASE_FRAC_BITS + 4;
    localparam logic [PW-1:0] RATIO_RESET = PW'(1) << PHASE_FRAC_BITS;

    logic [PW-1:0]          rate_ratio_reg;
    logic                   mono_reg;
    logic                   cfg_write;
    logic [srs_pkg::REG_IDX_W-1:0] cfg_idx;

    srs_pkg::cmd_t          cmd;
    srs_pkg::status_t       st;

    logic [SAMPLE_BITS-1:0] left_out, right_out;

    // apb: always ready, write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[2:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_ratio_reg <= RATIO_RESET;
            mono_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                srs_pkg::REG_RATE_RATIO: rate_ratio_reg <= pwdata[PW-1:0];
                srs_pkg::REG_MONO:       mono_reg       <= pwdata[0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            srs_pkg::REG_RATE_RATIO: prdata = 32'(rate_ratio_reg);
            srs_pkg::REG_MONO:       prdata = {31'd0, mono_reg};
            default:                 prdata = '0;
        endcase
    end

    // control sequencing
    srs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // arithmetic and storage; output register parts the two stream sides
    srs_datapath #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .left_in     (s_tdata[SAMPLE_BITS-1:0]),
        .right_in    (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .rate_ratio  (rate_ratio_reg),
        .mono_source (mono_reg),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .left_out    (left_out),
        .right_out   (right_out),
        .m_tlast     (m_tlast)
    );

    // pack result fields, pad bits stay zero
    always_comb
    begin
        m_tdata                                  = '0;
        m_tdata[SAMPLE_BITS-1:0]                 = left_out;
        m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]     = right_out;
    end

    // never overwrite a result that has not been taken
    `SRS_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.load_interp || cmd.load_bypass, st.out_free)
    // at most one of multiply, interpolated load, bypass load and finish per cycle
    `SRS_ASSERT_ALWAYS(a_one_action, clk, rst_n,
        $onehot0({cmd.mul_step, cmd.load_interp, cmd.load_bypass, cmd.finish}))
    // no new item while a result is being built
    `SRS_ASSERT_IMPL(a_idle_only, clk, rst_n, s_tready, !cmd.mul_step && !cmd.load_interp)

endmodule

// ===== tb/sv/stereo_linear_resampler_test.sv =====
// self-checking testbench for the stereo linear resampler
module stereo_linear_resampler_test;

    localparam logic [31:0] PHASE_ONE        = 32'h0001_0000;
    localparam logic [31:0] RATIO_MIN        = PHASE_ONE >> 3;
    localparam logic [31:0] RATIO_MAX        = PHASE_ONE << 3;
    localparam int          ITEMS_PER_PHASE  = 22;
    localparam int          RANDOM_PHASES    = 9;
    // settle time after the last result
    localparam int          SETTLE_CYCLES    = 40;
    localparam int          RECV_HOLD_CYCLES = 300;
    localparam int          WATCHDOG_LIMIT   = 2000;

    typedef logic signed [15:0] sample_t;

    typedef struct {
        sample_t left;
        sample_t right;
    } in_frame_t;

    typedef struct {
        sample_t left;
        sample_t right;
        logic    last;
    } out_frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // left_in, right_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // left_out, right_out
    logic        m_tlast;          // last_of_run

    stereo_linear_resampler u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // stimulus and expected result stores
    in_frame_t  pending_frames[$];
    out_frame_t expected_frames[$];
    in_frame_t  on_bus;
    bit         offering = 1'b0;

    // idling knobs, percent of cycles
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    int error_count = 0;
    int quiet_cycles = 0;

    // predictor state and its copy of the registers
    logic [19:0] ratio_cfg = PHASE_ONE[19:0];
    logic        mono_cfg = 1'b0;
    sample_t     prev_left_q = '0;
    sample_t     prev_right_q = '0;
    logic [31:0] phase_acc = '0;
    logic        have_prev = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    // prev + (cur - prev) * phase, rounded half up, done on a biased value
    function automatic sample_t interp_sample(input sample_t a, input sample_t b,
                                              input logic [31:0] ph);
        longint acc;
        longint q;
        acc = (longint'(a) + 32768) * 65536 + (longint'(b) - longint'(a)) * longint'(ph)
              + 32768;
        q = (acc >>> 16) - 32768;
        return q[15:0];
    endfunction

    // works out every result one accepted item causes
    task automatic predict_frame(input in_frame_t item);
        sample_t     cur_l;
        sample_t     cur_r;
        logic [31:0] step;
        out_frame_t  f;
        out_frame_t  batch[$];
        cur_l = item.left;
        cur_r = mono_cfg ? item.left : item.right;
        if (32'(ratio_cfg) == PHASE_ONE)
        begin
            // unity ratio passes the frame straight through
            f.left = cur_l;
            f.right = cur_r;
            f.last = 1'b1;
            batch = {batch, f};
        end
        else if (have_prev)
        begin
            step = 32'(ratio_cfg);
            if (step < RATIO_MIN)
                step = RATIO_MIN;
            if (step > RATIO_MAX)
                step = RATIO_MAX;
            while (phase_acc < PHASE_ONE && batch.size() < srs_pkg::MAX_RESULTS)
            begin
                f.left = interp_sample(prev_left_q, cur_l, phase_acc);
                f.right = interp_sample(prev_right_q, cur_r, phase_acc);
                f.last = 1'b0;
                batch = {batch, f};
                phase_acc += step;
            end
            if (batch.size() != 0)
                batch[batch.size() - 1].last = 1'b1;
            if (phase_acc >= PHASE_ONE)
                phase_acc -= PHASE_ONE;
            else
                phase_acc = '0;
        end
        foreach (batch[i])
            expected_frames = {expected_frames, batch[i]};
        prev_left_q = cur_l;
        prev_right_q = cur_r;
        have_prev = 1'b1;
    endtask

    // input side: offers queued items, predicts on every accepted one
    always @(posedge clk)
    begin : drive_input
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_frame(on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (pending_frames.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    on_bus = pending_frames.pop_front();
                    offering = 1'b1;
                    s_tdata <= {on_bus.right, on_bus.left};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    offering = 1'b0;
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: checks each accepted result against the oldest expectation
    always @(posedge clk)
    begin : check_output
        out_frame_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_frames.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h last %b",
                                              m_tdata, m_tlast));
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (m_tdata[15:0] !== want.left)
                        report_mismatch($sformatf("left_out %h, want %h",
                                                  m_tdata[15:0], want.left));
                    if (m_tdata[31:16] !== want.right)
                        report_mismatch($sformatf("right_out %h, want %h",
                                                  m_tdata[31:16], want.right));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last_of_run %b, want %b",
                                                  m_tlast, want.last));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // setup then access cycle; the register takes the value on the access edge
    task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == srs_pkg::REG_RATE_RATIO)
            ratio_cfg = value[19:0];
        else if (idx == srs_pkg::REG_MONO)
            mono_cfg = value[0];
    endtask

    task automatic push_frame(input sample_t l, input sample_t r);
        in_frame_t item;
        item.left = l;
        item.right = r;
        pending_frames = {pending_frames, item};
    endtask

    // sender pauses here until every expected result has come
    task automatic wait_idle();
        while (pending_frames.size() != 0 || offering || expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return $urandom_range(1) ? 16'sh0000 : 16'shFFFF;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // mostly in range, some at the limits and some clamped or with junk upper bits
    function automatic logic [31:0] pick_ratio();
        case ($urandom_range(9))
            0: return RATIO_MIN;
            1: return RATIO_MAX;
            2: return PHASE_ONE;
            3: return $urandom;
            4: return $urandom_range(RATIO_MIN - 1);
            default: return $urandom_range(RATIO_MAX, RATIO_MIN);
        endcase
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        send_gap_pct = 23;
        recv_stall_pct = 48;

        // reset settings: unity ratio passes even the first frame
        push_frame(16'sh7FFF, 16'sh8000);
        push_frame(16'sh8000, 16'sh7FFF);
        push_frame(16'sh0000, 16'shFFFF);
        push_frame(16'shFFFF, 16'sh0000);
        wait_idle();

        // half ratio: midpoints, ties round up
        reg_write(srs_pkg::REG_RATE_RATIO, 32'h0000_8000);
        push_frame(16'sh8000, 16'sh7FFF);
        push_frame(16'sh7FFF, 16'sh8000);
        push_frame(16'sh0001, 16'shFFFF);
        push_frame(16'sh0000, 16'sh0000);
        push_frame(16'shFFFF, 16'sh0001);
        wait_idle();

        // mono, ratio 3: most items give no result
        reg_write(srs_pkg::REG_MONO, 32'h1);
        reg_write(srs_pkg::REG_RATE_RATIO, 32'h0003_0000);
        push_frame(16'sh0064, 16'sh1388);
        push_frame(16'sh8000, 16'sh007B);
        push_frame(16'sh7FFF, 16'shFFFB);
        push_frame(16'sh0007, 16'sh0007);
        push_frame(16'shFFFD, 16'sh0009);
        wait_idle();

        // ratio below the range clamps to 1/8: eight results per item
        reg_write(srs_pkg::REG_MONO, 32'h0);
        reg_write(srs_pkg::REG_RATE_RATIO, 32'h0000_0000);
        push_frame(16'sh7FFF, 16'sh8000);
        push_frame(16'sh8000, 16'sh7FFF);
        wait_idle();

        // ratio above the range clamps to 8
        reg_write(srs_pkg::REG_RATE_RATIO, 32'h000F_FFFF);
        push_frame(16'sh1234, 16'shEDCB);
        push_frame(16'sh8000, 16'sh8000);
        push_frame(16'sh7FFF, 16'sh7FFF);
        wait_idle();

        // upper data bits are dropped, leaving exactly unity
        reg_write(srs_pkg::REG_RATE_RATIO, 32'hABC1_0000);
        push_frame(16'sh4321, 16'shBCDE);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 3)
            begin
                send_gap_pct = 23;
                recv_stall_pct = 48;
            end
            else if (p < 6)
            begin
                send_gap_pct = 48;
                recv_stall_pct = 23;
            end
            else
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            reg_write(srs_pkg::REG_RATE_RATIO, pick_ratio());
            reg_write(srs_pkg::REG_MONO, $urandom);
            // receiver blocks while the sender keeps offering, so the input backs up
            if (p == 6)
            begin
                @(posedge clk);
                hold_left <= RECV_HOLD_CYCLES;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                push_frame(rand_sample(), rand_sample());
            wait_idle();
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/srs_pkg.sv
rtl/core/srs_datapath.sv
rtl/core/srs_controller.sv
rtl/core/stereo_linear_resampler.sv
tb/sv/stereo_linear_resampler_test.sv
